/* hw/rtl/semn_pkg.sv */
// Package for the Sobel edge magnitude block: payload structs, controller
// states, command/status structs and shared constants. No dependencies.
package semn_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int SUM_W      = 11;
    localparam int DIM_W      = 9;
    localparam logic [17:0] SCALE = 18'd260100;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       last;
        logic       not_ready;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SEARCH,
        ST_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic restart;
        logic load;
        logic fetch_rd;
        logic search_init;
        logic search_step;
    } dp_cmd_t;

    typedef struct packed {
        logic complete;
        logic search_done;
    } dp_status_t;

endpackage

/* hw/rtl/sobel_edge_magnitude_normalized_top.sv */
// Top level of the Sobel edge magnitude block with normalisation.
// Depends on semn_pkg, semn_ctrl and semn_datapath.
//
// Usage: s_ channel carries commands (load pixel / fetch result) with
// valid/ready; each transfer with cmd = load consumes one pixel in raster
// order at one pixel per cycle while no fetch is pending, and gives no
// result. A fetch gives one result transfer on the m_ channel. A fetch
// before the frame is complete raises m_valid with not_ready = 1 right after
// its transfer, so the result can be taken at the next edge. A ready fetch
// reads the sum store, then runs an eight-step bit search for
// round(255*sqrt(s/smax)); each step squares, then multiply-compares against
// the peak, and m_valid rises once the last step is done. Border pixels are
// never stored; the fetch path forces their sum to zero from its own
// row/column count.
// One fetch is in flight at a time; s_ready is low until the result has been
// taken, so a stalled m_ready simply holds the result. Config writes (cfg_we,
// cfg_index, cfg_data) set frame width/height and abort the frame in progress.
// Synchronous active-low reset sets both dimensions to 256 and clears the
// counters and peak. The stores have no reset.
module sobel_edge_magnitude_normalized_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [8:0]            cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  semn_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output semn_pkg::out_item_t   m_data
);
    import semn_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [7:0] ev;
    logic       lst, nr;

    semn_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .item(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_not_ready(nr),
        .cmd(cmd), .status(status)
    );

    semn_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .item(s_data), .cmd(cmd), .status(status),
        .edge_value(ev), .last(lst)
    );

    // not-ready results carry zero value and last
    assign m_data.edge_value = nr ? 8'd0 : ev;
    assign m_data.last       = nr ? 1'b0 : lst;
    assign m_data.not_ready  = nr;
endmodule

/* hw/rtl/semn_datapath.sv */
// Datapath: line stores, window, sum store, peak tracker and the
// normalising search. Depends on semn_pkg.
module semn_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_idx,
    input  logic [8:0]           cfg_data,
    input  semn_pkg::in_item_t   item,
    input  semn_pkg::dp_cmd_t    cmd,
    output semn_pkg::dp_status_t status,
    output logic [7:0]           edge_value,
    output logic                 last
);
    import semn_pkg::*;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             complete_reg;
    logic [SUM_W-1:0] peak_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [COL_W-1:0] rd_col_reg;
    logic [ROW_W-1:0] rd_row_reg;
    logic [7:0]       win_reg [9];
    logic [7:0]       line_mem [2*MAX_WIDTH];
    logic [SUM_W-1:0] sum_mem [MAX_WIDTH*MAX_HEIGHT];
    logic [7:0]       lc_q, lp_q;
    logic [SUM_W-1:0] s_reg;
    logic             brd_reg;
    logic             last_reg;
    logic [7:0]       k_reg;
    logic [7:0]       bit_reg;
    logic [3:0]       step_reg;

    // clamped dimensions
    logic [DIM_W-1:0] w_c, h_c;
    always_comb begin
        w_c = (width_reg < 9'd3) ? 9'd3 :
              (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
        h_c = (height_reg < 9'd3) ? 9'd3 :
              (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;
    end

    logic [DIM_W-1:0] c9, r9;
    logic col_end, row_end;
    logic [ADDR_W-1:0] in_addr, cen_addr, total_m1;
    assign c9 = {1'b0, col_reg};
    assign r9 = {1'b0, row_reg};
    assign col_end = (c9 + 9'd1 >= w_c);
    assign row_end = (r9 + 9'd1 >= h_c);
    // row*w + col; w is a narrow value, one multiply
    assign in_addr  = ADDR_W'(row_reg) * ADDR_W'(w_c) + ADDR_W'(col_reg);
    assign cen_addr = in_addr - ADDR_W'(w_c) - ADDR_W'(1);
    assign total_m1 = ADDR_W'(w_c * h_c - 18'd1);

    // border pixels are never stored; the read side forces them to zero
    logic rd_border;
    assign rd_border = (rd_row_reg == '0) || ({1'b0, rd_row_reg} == h_c - 9'd1) ||
                       (rd_col_reg == '0) || ({1'b0, rd_col_reg} == w_c - 9'd1);

    // window after shift uses the line reads
    logic [7:0] p0, p1, p2, p3, p5, p6, p7, p8;
    assign p0 = win_reg[1]; assign p1 = win_reg[2]; assign p2 = lc_q;
    assign p3 = win_reg[4]; assign p5 = lp_q;
    assign p6 = win_reg[7]; assign p7 = win_reg[8]; assign p8 = item.pixel;

    logic [9:0] lft, rgt, top, bot;
    logic [SUM_W-1:0] s_new;
    always_comb begin
        lft = 10'(p0) + {1'b0, p3, 1'b0} + 10'(p6);
        rgt = 10'(p2) + {1'b0, p5, 1'b0} + 10'(p8);
        top = 10'(p0) + {1'b0, p1, 1'b0} + 10'(p2);
        bot = 10'(p6) + {1'b0, p7, 1'b0} + 10'(p8);
        s_new = SUM_W'((rgt >= lft) ? rgt - lft : lft - rgt) +
                SUM_W'((top >= bot) ? top - bot : bot - top);
    end
    logic inner;
    assign inner = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));

    // line store is read one load ahead: each load fetches both lines at the
    // next raster position into lc_q/lp_q
    logic [COL_W-1:0] nxt_col;
    logic             nxt_par;
    assign nxt_col = col_end ? '0 : col_reg + COL_W'(1);
    assign nxt_par = col_end ? (row_end ? 1'b0 : ~row_reg[0]) : row_reg[0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            line_mem[{row_reg[0], col_reg}] <= item.pixel;
            lc_q <= line_mem[{nxt_par, nxt_col}];
            lp_q <= line_mem[{~nxt_par, nxt_col}];
            win_reg[0] <= win_reg[1]; win_reg[1] <= win_reg[2]; win_reg[2] <= lc_q;
            win_reg[3] <= win_reg[4]; win_reg[4] <= win_reg[5]; win_reg[5] <= lp_q;
            win_reg[6] <= win_reg[7]; win_reg[7] <= win_reg[8]; win_reg[8] <= item.pixel;
            if (inner) sum_mem[cen_addr] <= s_new;
        end
        if (cmd.fetch_rd) begin
            s_reg    <= sum_mem[rd_idx_reg];
            brd_reg  <= rd_border;
            last_reg <= (rd_idx_reg == total_m1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= 9'd256;
            height_reg   <= 9'd256;
            col_reg      <= '0;
            row_reg      <= '0;
            complete_reg <= 1'b0;
            peak_reg     <= '0;
            rd_idx_reg   <= '0;
            rd_col_reg   <= '0;
            rd_row_reg   <= '0;
        end else if (cfg_we) begin
            if (cfg_idx == REG_WIDTH) width_reg <= cfg_data;
            else                      height_reg <= cfg_data;
            col_reg <= '0; row_reg <= '0; complete_reg <= 1'b0;
            peak_reg <= '0; rd_idx_reg <= '0;
            rd_col_reg <= '0; rd_row_reg <= '0;
        end else if (cmd.load) begin
            if (cmd.restart) begin
                complete_reg <= 1'b0;
                peak_reg     <= (inner && s_new > SUM_W'(0)) ? s_new : '0;
            end else if (inner && s_new > peak_reg) begin
                peak_reg <= s_new;
            end
            if (col_end) begin
                col_reg <= '0;
                if (row_end) begin
                    row_reg <= '0; complete_reg <= 1'b1; rd_idx_reg <= '0;
                    rd_col_reg <= '0; rd_row_reg <= '0;
                end else row_reg <= row_reg + ROW_W'(1);
            end else col_reg <= col_reg + COL_W'(1);
        end else if (cmd.fetch_rd) begin
            if (rd_idx_reg >= total_m1) begin
                rd_idx_reg <= '0; rd_col_reg <= '0; rd_row_reg <= '0;
            end else begin
                rd_idx_reg <= rd_idx_reg + ADDR_W'(1);
                if ({1'b0, rd_col_reg} + 9'd1 >= w_c) begin
                    rd_col_reg <= '0;
                    rd_row_reg <= rd_row_reg + ROW_W'(1);
                end else rd_col_reg <= rd_col_reg + COL_W'(1);
            end
        end
    end

    // restoring search: k grows one bit per step, MSB first (8 steps)
    logic [SUM_W-1:0] s_eff;
    logic [7:0]  k_try;
    logic [8:0]  odd;
    logic [17:0] odd_sq_reg;
    logic [28:0] lhs;
    logic [28:0] rhs;
    assign s_eff = brd_reg ? '0 : s_reg;
    assign k_try = k_reg | bit_reg;
    assign odd   = {k_try, 1'b0} - 9'd1;
    assign lhs   = odd_sq_reg * peak_reg;
    assign rhs   = SCALE * s_eff;
    logic [17:0] odd_sq_next;
    assign odd_sq_next = odd * odd;
    logic phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0; phase_reg <= 1'b0; k_reg <= '0; bit_reg <= '0;
        end else if (cmd.search_init) begin
            k_reg <= '0; bit_reg <= 8'h80; step_reg <= '0; phase_reg <= 1'b0;
        end else if (cmd.search_step && step_reg != 4'd8) begin
            if (!phase_reg) begin
                odd_sq_reg <= odd_sq_next;
                phase_reg  <= 1'b1;
            end else begin
                if (lhs <= rhs && peak_reg != '0) k_reg <= k_try;
                bit_reg   <= bit_reg >> 1;
                step_reg  <= step_reg + 4'd1;
                phase_reg <= 1'b0;
            end
        end
    end

    assign status.complete    = complete_reg;
    assign status.search_done = (step_reg == 4'd8);
    assign edge_value = k_reg;
    assign last       = last_reg;
endmodule

/* hw/rtl/semn_ctrl.sv */
// Controller state machine: handshakes and datapath sequencing.
// Depends on semn_pkg.
module semn_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  semn_pkg::in_item_t   item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_not_ready,
    output semn_pkg::dp_cmd_t    cmd,
    input  semn_pkg::dp_status_t status
);
    import semn_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic nr_reg, nr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            nr_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            nr_reg    <= nr_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        nr_next    = nr_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (item.cmd == CMD_LOAD) begin
                        cmd.load    = 1'b1;
                        cmd.restart = status.complete;
                    end else if (!status.complete) begin
                        nr_next    = 1'b1;
                        state_next = ST_HOLD;
                    end else begin
                        cmd.fetch_rd = 1'b1;
                        nr_next      = 1'b0;
                        state_next   = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.search_init = 1'b1;
                state_next      = ST_SEARCH;
            end
            ST_SEARCH: begin
                cmd.search_step = 1'b1;
                if (status.search_done) state_next = ST_HOLD;
            end
            ST_HOLD: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_not_ready = nr_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while result pending");
    a_search_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_SEARCH))
        else $error("read not followed by search");
    a_fetch_nr: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && item.cmd == CMD_FETCH && !status.complete)
        |=> (m_valid && m_not_ready)) else $error("early fetch not flagged");
`endif
endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for sobel_edge_magnitude_normalized_top: loads gray
// frames, fetches normalised edge values and checks them against a local model.
// Depends on semn_pkg and the RTL top level only.
module testbench;
    import semn_pkg::*;

    localparam int N_RAND_FRAMES = 7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = REG_WIDTH;
    logic [8:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    always #10 aclk = ~aclk;

    sobel_edge_magnitude_normalized_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // ---------------- edge model ----------------
    logic [7:0]  mdl_lines [2*MAX_WIDTH];
    logic [7:0]  mdl_win [9];
    logic [10:0] mdl_sums [MAX_WIDTH*MAX_HEIGHT];
    int unsigned mdl_row, mdl_col, mdl_peak, mdl_rd, mdl_w_reg, mdl_h_reg;
    bit          mdl_complete;

    out_item_t   edge_q[$];
    int          n_fail = 0;
    bit          fast_phase = 0;   // no idling on either side
    bit          hold_recv = 0;    // receiver held off for a stretch

    function automatic int unsigned clamp_dim(int unsigned v);
        return v < 3 ? 3 : (v > 256 ? 256 : v);
    endfunction

    function automatic int unsigned absd(int unsigned a, int unsigned b);
        return a >= b ? a - b : b - a;
    endfunction

    // count of odd k-steps under the scaled ratio: round(255*sqrt(s/smax))
    function automatic logic [7:0] norm_edge(int unsigned s, int unsigned smax);
        int unsigned n;
        longint unsigned odd;
        n = 0;
        if (smax == 0) return 8'd0;
        for (int k = 1; k <= 255; k++) begin
            odd = 2 * k - 1;
            if (odd * odd * smax <= 64'd260100 * s) n++;
        end
        return n[7:0];
    endfunction

    task automatic frame_restart();
        mdl_row = 0; mdl_col = 0; mdl_complete = 0; mdl_peak = 0; mdl_rd = 0;
    endtask

    task automatic edge_predict(input in_item_t it);
        int unsigned w, h, r, c, cur, prv, lf, rt, tp, bt, s, tot, idx;
        out_item_t o;
        w = clamp_dim(mdl_w_reg);
        h = clamp_dim(mdl_h_reg);
        if (it.cmd == CMD_LOAD) begin
            if (mdl_complete) frame_restart();
            r = mdl_row; c = mdl_col;
            cur = (r & 1) * MAX_WIDTH;
            prv = ((r + 1) & 1) * MAX_WIDTH;
            for (int i = 0; i < 3; i++) begin
                mdl_win[i*3] = mdl_win[i*3+1];
                mdl_win[i*3+1] = mdl_win[i*3+2];
            end
            mdl_win[2] = mdl_lines[cur + c];
            mdl_win[5] = mdl_lines[prv + c];
            mdl_win[8] = it.pixel;
            mdl_lines[cur + c] = it.pixel;
            if (r == 0 || r == h - 1 || c == 0 || c == w - 1) mdl_sums[r*w + c] = 0;
            if (r >= 2 && c >= 2) begin
                lf = mdl_win[0] + 2 * mdl_win[3] + mdl_win[6];
                rt = mdl_win[2] + 2 * mdl_win[5] + mdl_win[8];
                tp = mdl_win[0] + 2 * mdl_win[1] + mdl_win[2];
                bt = mdl_win[6] + 2 * mdl_win[7] + mdl_win[8];
                s = absd(rt, lf) + absd(tp, bt);
                mdl_sums[(r-1)*w + (c-1)] = s[10:0];
                if (s > mdl_peak) mdl_peak = s;
            end
            if (c + 1 >= w) begin
                mdl_col = 0;
                if (r + 1 >= h) begin
                    mdl_row = 0; mdl_complete = 1; mdl_rd = 0;
                end else mdl_row = r + 1;
            end else mdl_col = c + 1;
        end else if (!mdl_complete) begin
            o = '{edge_value: 8'd0, last: 1'b0, not_ready: 1'b1};
            edge_q.push_back(o);
        end else begin
            tot = w * h;
            idx = mdl_rd < tot ? mdl_rd : 0;
            o.edge_value = norm_edge(mdl_sums[idx], mdl_peak);
            o.last = (idx + 1 == tot);
            o.not_ready = 1'b0;
            edge_q.push_back(o);
            mdl_rd = (idx + 1 >= tot) ? 0 : idx + 1;
        end
    endtask

    // ---------------- result checking ----------------
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (edge_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result %p", m_data);
            end else begin
                want = edge_q.pop_front();
                if (m_data !== want) begin
                    n_fail++;
                    if (n_fail <= 10) $display("mismatch: expected %p, got %p", want, m_data);
                end
            end
        end
    end

    // receiver: random idling, fast stretches and one long hold-off
    always @(posedge aclk) begin
        if (hold_recv) m_ready <= 1'b0;
        else if (fast_phase) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(99) >= 33);
    end

    // ---------------- stimulus ----------------
    // valid stays high after the transfer; drain, or an idle wait in the next send, takes it down
    task automatic send(input logic cmd, input logic [7:0] px);
        in_item_t it;
        it.cmd = cmd; it.pixel = px;
        if (!fast_phase)
            while ($urandom_range(99) < 33) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        edge_predict(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (edge_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);   // extra settling; with the queue empty no fetch is still in the search
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_WIDTH) mdl_w_reg = val; else mdl_h_reg = val;
        frame_restart();
        @(posedge aclk);
    endtask

    // random frame: mostly random pixels, sometimes flat or checkerboard
    task automatic run_frame(input int unsigned w, input int unsigned h, input int kind,
                             input int unsigned n_fetch);
        logic [7:0] px;
        for (int r = 0; r < clamp_dim(h); r++)
            for (int c = 0; c < clamp_dim(w); c++) begin
                case (kind)
                    0: px = $urandom_range(255);
                    1: px = 8'd77;
                    default: px = ((r + c) & 1) ? 8'hFF : 8'h00;
                endcase
                if ($urandom_range(15) == 0) send(CMD_FETCH, 8'($urandom));
                send(CMD_LOAD, px);
            end
        for (int i = 0; i < n_fetch; i++)
            send(CMD_FETCH, 8'($urandom));
    endtask

    // directed rows: cmd, pixel, whether a known result is typed in, that result
    typedef struct {
        logic      cmd;
        logic [7:0] px;
        bit        typed;
        out_item_t res;
    } stim_row_t;

    stim_row_t dir_rows[] = '{
        '{CMD_FETCH, 8'h00, 1, '{8'd0, 1'b0, 1'b1}},   // fetch straight after reset
        '{CMD_LOAD,  8'h00, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_LOAD,  8'hFF, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_LOAD,  8'h00, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_FETCH, 8'hFF, 1, '{8'd0, 1'b0, 1'b1}},   // fetch mid-frame
        '{CMD_LOAD,  8'hFF, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_LOAD,  8'h00, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_LOAD,  8'hFF, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_LOAD,  8'h00, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_LOAD,  8'hFF, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_LOAD,  8'h80, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_FETCH, 8'h00, 1, '{8'd0, 1'b0, 1'b0}},   // corner is border: zero
        '{CMD_FETCH, 8'h00, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_FETCH, 8'h00, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_FETCH, 8'h00, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_FETCH, 8'h00, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_FETCH, 8'h00, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_FETCH, 8'h00, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_FETCH, 8'h00, 0, '{8'd0, 1'b0, 1'b0}},
        '{CMD_FETCH, 8'h00, 1, '{8'd0, 1'b1, 1'b0}},   // final pixel flagged
        '{CMD_FETCH, 8'h00, 1, '{8'd0, 1'b0, 1'b0}},   // wraps to pixel 0
        '{CMD_LOAD,  8'h12, 0, '{8'd0, 1'b0, 1'b0}},   // load after complete restarts
        '{CMD_FETCH, 8'h00, 1, '{8'd0, 1'b0, 1'b1}}
    };

    initial begin
        frame_restart();
        mdl_w_reg = 256; mdl_h_reg = 256;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part on a 3x3 frame
        write_reg(REG_WIDTH, 9'd3);
        write_reg(REG_HEIGHT, 9'd3);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].typed) begin
                send(dir_rows[i].cmd, dir_rows[i].px);
                if (edge_q.size() != 0 && edge_q[$] !== dir_rows[i].res) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("row %0d: expected %p, model %p", i, dir_rows[i].res, edge_q[$]);
                end
            end else send(dir_rows[i].cmd, dir_rows[i].px);
        end
        drain();

        // out-of-range dimensions saturate into 3..256
        write_reg(REG_WIDTH, 9'd0);
        write_reg(REG_HEIGHT, 9'h1FF);   // saturates to 256 rows... keep width small
        write_reg(REG_HEIGHT, 9'd2);
        run_frame(0, 2, 2, 10);
        drain();

        // the sender pauses until everything is back
        for (int f = 0; f < N_RAND_FRAMES; f++) begin
            int unsigned w, h;
            w = $urandom_range(3, 9);
            h = $urandom_range(3, 7);
            write_reg(REG_WIDTH, 9'(w));
            write_reg(REG_HEIGHT, 9'(h));
            fast_phase = (f == 2);
            if (f == 4) begin
                // long receiver hold-off while loads and fetches keep coming
                fork
                    begin
                        hold_recv = 1;
                        repeat (300) @(posedge aclk);
                        hold_recv = 0;
                    end
                    run_frame(w, h, 0, w * h + $urandom_range(3));
                join
            end else run_frame(w, h, f % 5 == 3 ? 1 : (f % 5 == 1 ? 2 : 0),
                               w * h + $urandom_range(3));
            fast_phase = 0;
            drain();
        end

        // full-width frame: an oversized width saturates to 256, kept short in
        // height, first row read back
        write_reg(REG_WIDTH, 9'h1FF);
        write_reg(REG_HEIGHT, 9'd3);
        run_frame(9'h1FF, 3, 0, 256);
        drain();

        if (n_fail == 0) $display("sobel_edge_magnitude_normalized_top verification clean");
        else $display("sobel_edge_magnitude_normalized_top verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("sobel_edge_magnitude_normalized_top verification failed");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/semn_pkg.sv
hw/rtl/semn_datapath.sv
hw/rtl/semn_ctrl.sv
hw/rtl/sobel_edge_magnitude_normalized_top.sv
bench/testbench.sv
